[hdl/assert_macros.svh]
// Assertion macros used by the lossy counting table back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define LCFK_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition is followed by another in the next cycle.
`define LCFK_CHECK_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

[hdl/lcfk_pkg.sv]
// Shared constants and types of the lossy counting frequent-key table.
package lcfk_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_BITS = 64;
    localparam int IDX_BITS = $clog2(TABLE_DEPTH);
    localparam int ADDR_CNT_BITS = IDX_BITS + 1;
    localparam int BW_BITS = 20;

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NOP = 2'd3;

    typedef struct packed {
        logic                live;
        logic [KEY_BITS-1:0] key;
        logic [31:0]         count;
        logic [31:0]         err;
    } slot_t;

    localparam int SLOT_BITS = $bits(slot_t);

    typedef struct packed {
        logic [9:0]  entry_index;
        logic [63:0] element_key;
        logic [1:0]  action;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_out_t;

    typedef struct packed {
        logic        table_full;
        logic [31:0] current_bucket;
        logic [31:0] elements_seen;
        logic        above_cutoff;
        logic [31:0] entry_error;
        logic [31:0] entry_count;
        logic [63:0] entry_key;
        logic        entry_valid;
    } result_t;

endpackage

[hdl/lcfk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lcfk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/lcfk_front.sv]
// Front end: accepts items and holds them in a two-entry queue for the engine.
module lcfk_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    input  lcfk_pkg::cmd_t      s_cmd,
    output lcfk_pkg::queue_out_t q_out,
    input  logic                pop
);

    lcfk_pkg::cmd_t q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       do_pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign push = s_valid && s_ready;
    assign do_pop = pop && (cnt_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= s_cmd;
        end
    end

    assign q_out.valid = (cnt_reg != 2'd0);
    assign q_out.cmd = q_mem_reg[rd_ptr_reg];

endmodule

[hdl/lcfk_back.sv]
// Back end: runs add, read, clear and prune over the slot memory.
`include "assert_macros.svh"

module lcfk_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lcfk_pkg::queue_out_t            q_in,
    output logic                            cmd_pop,
    input  logic [lcfk_pkg::BW_BITS-1:0]    bucket_size,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lcfk_pkg::result_t               out_res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_ADD_END = 3'd3;
    localparam logic [2:0] ST_PRUNE = 3'd4;
    localparam logic [2:0] ST_READ = 3'd5;
    localparam logic [2:0] ST_MUL = 3'd6;
    localparam logic [2:0] ST_CMP = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [lcfk_pkg::ADDR_CNT_BITS-1:0] addr_reg, addr_next;
    logic pend_reg, pend_next;
    logic [lcfk_pkg::IDX_BITS-1:0] pend_addr_reg, pend_addr_next;
    logic free_found_reg, free_found_next;
    logic [lcfk_pkg::IDX_BITS-1:0] free_addr_reg, free_addr_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] bucket_reg, bucket_next;
    logic [lcfk_pkg::BW_BITS-1:0] fill_reg, fill_next;
    logic ovf_reg, ovf_next;
    logic clr_emit_reg, clr_emit_next;
    logic range_reg, range_next;
    logic out_valid_reg, out_valid_next;

    logic [lcfk_pkg::KEY_BITS-1:0] key_reg, key_next;
    lcfk_pkg::slot_t ent_reg, ent_next;
    lcfk_pkg::slot_t out_ent_reg, out_ent_next;
    logic above_reg, above_next;
    logic [51:0] prod_reg, prod_next;
    logic [35:0] nine_reg, nine_next;

    logic ram_we;
    logic [lcfk_pkg::IDX_BITS-1:0] ram_waddr;
    lcfk_pkg::slot_t ram_wdata;
    logic [lcfk_pkg::IDX_BITS-1:0] ram_raddr;
    logic [lcfk_pkg::SLOT_BITS-1:0] ram_rdata;
    lcfk_pkg::slot_t rd;

    logic [lcfk_pkg::BW_BITS-1:0] width_used;
    logic issue;
    logic at_end;
    logic [lcfk_pkg::BW_BITS-1:0] fill_inc;

    lcfk_ram #(
        .WIDTH(lcfk_pkg::SLOT_BITS),
        .DEPTH(lcfk_pkg::TABLE_DEPTH)
    ) u_slots (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd = lcfk_pkg::slot_t'(ram_rdata);
    assign width_used = (bucket_size == '0) ? lcfk_pkg::BW_BITS'(1) : bucket_size;
    assign at_end = (addr_reg == lcfk_pkg::ADDR_CNT_BITS'(lcfk_pkg::TABLE_DEPTH));
    assign issue = ((state_reg == ST_SCAN) || (state_reg == ST_PRUNE)) && !at_end;
    assign fill_inc = fill_reg + lcfk_pkg::BW_BITS'(1);
    assign ram_raddr = (state_reg == ST_IDLE) ?
                       lcfk_pkg::IDX_BITS'(q_in.cmd.entry_index) :
                       addr_reg[lcfk_pkg::IDX_BITS-1:0];

    always_comb
    begin
        state_next = state_reg;
        addr_next = addr_reg;
        pend_next = pend_reg;
        pend_addr_next = pend_addr_reg;
        free_found_next = free_found_reg;
        free_addr_next = free_addr_reg;
        total_next = total_reg;
        bucket_next = bucket_reg;
        fill_next = fill_reg;
        ovf_next = ovf_reg;
        clr_emit_next = clr_emit_reg;
        range_next = range_reg;
        out_valid_next = out_valid_reg && !out_ready;
        key_next = key_reg;
        ent_next = ent_reg;
        out_ent_next = out_ent_reg;
        above_next = above_reg;
        prod_next = prod_reg;
        nine_next = nine_reg;
        cmd_pop = 1'b0;
        ram_we = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = rd;

        if (issue)
        begin
            addr_next = addr_reg + lcfk_pkg::ADDR_CNT_BITS'(1);
            pend_addr_next = addr_reg[lcfk_pkg::IDX_BITS-1:0];
        end
        if ((state_reg == ST_SCAN) || (state_reg == ST_PRUNE))
        begin
            pend_next = issue;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_in.valid && !out_valid_reg)
                begin
                    cmd_pop = 1'b1;
                    case (q_in.cmd.action)
                        lcfk_pkg::ACT_ADD:
                        begin
                            key_next = lcfk_pkg::KEY_BITS'(q_in.cmd.element_key);
                            addr_next = '0;
                            pend_next = 1'b0;
                            free_found_next = 1'b0;
                            state_next = ST_SCAN;
                        end
                        lcfk_pkg::ACT_READ:
                        begin
                            range_next = (32'(q_in.cmd.entry_index) < lcfk_pkg::TABLE_DEPTH);
                            state_next = ST_READ;
                        end
                        lcfk_pkg::ACT_CLEAR:
                        begin
                            total_next = '0;
                            bucket_next = 32'd1;
                            fill_next = '0;
                            ovf_next = 1'b0;
                            addr_next = '0;
                            clr_emit_next = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            out_ent_next = '0;
                            above_next = 1'b0;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                ram_waddr = addr_reg[lcfk_pkg::IDX_BITS-1:0];
                ram_wdata = '0;
                addr_next = addr_reg + lcfk_pkg::ADDR_CNT_BITS'(1);
                if (addr_reg == lcfk_pkg::ADDR_CNT_BITS'(lcfk_pkg::TABLE_DEPTH - 1))
                begin
                    if (clr_emit_reg)
                    begin
                        out_ent_next = '0;
                        above_next = 1'b0;
                        out_valid_next = 1'b1;
                    end
                    clr_emit_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && rd.live && (rd.key == key_reg))
                begin
                    ram_we = 1'b1;
                    ram_wdata = rd;
                    if (rd.count != '1)
                    begin
                        ram_wdata.count = rd.count + 32'd1;
                    end
                    pend_next = 1'b0;
                    state_next = ST_ADD_END;
                end
                else
                begin
                    if (pend_reg && !rd.live && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_addr_next = pend_addr_reg;
                    end
                    if (!pend_reg && at_end)
                    begin
                        if (free_found_reg)
                        begin
                            ram_we = 1'b1;
                            ram_waddr = free_addr_reg;
                            ram_wdata.live = 1'b1;
                            ram_wdata.key = key_reg;
                            ram_wdata.count = 32'd1;
                            ram_wdata.err = bucket_reg - 32'd1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        state_next = ST_ADD_END;
                    end
                end
            end
            ST_ADD_END:
            begin
                if (total_reg != '1)
                begin
                    total_next = total_reg + 32'd1;
                end
                if ((fill_inc >= width_used) || (fill_inc == '0))
                begin
                    fill_next = '0;
                    addr_next = '0;
                    pend_next = 1'b0;
                    state_next = ST_PRUNE;
                end
                else
                begin
                    fill_next = fill_inc;
                    out_ent_next = '0;
                    above_next = 1'b0;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PRUNE:
            begin
                if (pend_reg && rd.live &&
                    ({1'b0, rd.count} + {1'b0, rd.err} <= {1'b0, bucket_reg}))
                begin
                    ram_we = 1'b1;
                    ram_wdata = rd;
                    ram_wdata.live = 1'b0;
                end
                if (!pend_reg && at_end)
                begin
                    if (bucket_reg != '1)
                    begin
                        bucket_next = bucket_reg + 32'd1;
                    end
                    out_ent_next = '0;
                    above_next = 1'b0;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (range_reg && rd.live)
                begin
                    ent_next = rd;
                    state_next = ST_MUL;
                end
                else
                begin
                    out_ent_next = '0;
                    above_next = 1'b0;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                prod_next = 52'(ent_reg.count) * 52'(width_used);
                nine_next = {1'b0, total_reg, 3'b000} + 36'(total_reg);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                out_ent_next = ent_reg;
                above_next = (52'(nine_reg) < prod_reg);
                out_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg <= '0;
            pend_reg <= 1'b0;
            pend_addr_reg <= '0;
            free_found_reg <= 1'b0;
            free_addr_reg <= '0;
            total_reg <= '0;
            bucket_reg <= 32'd1;
            fill_reg <= '0;
            ovf_reg <= 1'b0;
            clr_emit_reg <= 1'b0;
            range_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg <= addr_next;
            pend_reg <= pend_next;
            pend_addr_reg <= pend_addr_next;
            free_found_reg <= free_found_next;
            free_addr_reg <= free_addr_next;
            total_reg <= total_next;
            bucket_reg <= bucket_next;
            fill_reg <= fill_next;
            ovf_reg <= ovf_next;
            clr_emit_reg <= clr_emit_next;
            range_reg <= range_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        ent_reg <= ent_next;
        out_ent_reg <= out_ent_next;
        above_reg <= above_next;
        prod_reg <= prod_next;
        nine_reg <= nine_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res.entry_valid = out_ent_reg.live;
    assign out_res.entry_key = 64'(out_ent_reg.key);
    assign out_res.entry_count = out_ent_reg.count;
    assign out_res.entry_error = out_ent_reg.err;
    assign out_res.above_cutoff = above_reg;
    assign out_res.elements_seen = total_reg;
    assign out_res.current_bucket = bucket_reg;
    assign out_res.table_full = ovf_reg;

    `LCFK_CHECK(a_bucket_nonzero, bucket_reg != 32'd0, "bucket number is zero")
    `LCFK_CHECK(a_pop_idle, cmd_pop |-> (state_reg == ST_IDLE && !out_valid_reg),
                "pop while busy")
    `LCFK_CHECK(a_write_state,
                ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_SCAN ||
                            state_reg == ST_PRUNE),
                "slot write outside table walk")
    `LCFK_CHECK_NEXT(a_cmp_emits, state_reg == ST_CMP, out_valid_reg && state_reg == ST_IDLE,
                     "read result not emitted")

endmodule

[hdl/lossy_counting_frequent_keys.sv]
// Top level of the lossy counting frequent-key table.
// Items enter a two-entry queue and are executed one at a time by the engine. An add walks
// the slot memory one slot per cycle and stops early when the key is found; when it
// closes a bucket, a prune walk over the whole slot memory follows. A read of a live slot
// passes the read, multiply and compare states; a free or out-of-range slot is answered
// from the read state. After reset and on every clear the whole memory is swept, during which
// no queued item is executed. The walks go through the single memory port pair of the slot RAM.
module lossy_counting_frequent_keys (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // action, element_key, entry_index, zero fill
    input  logic [79:0]   s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // entry_valid, entry_key, entry_count, entry_error, above_cutoff,
    // elements_seen, current_bucket, table_full, zero fill
    output logic [199:0]  m_axis_tdata,
    input  logic          cfg_we,
    input  logic [19:0]   cfg_wdata
);

    logic [lcfk_pkg::BW_BITS-1:0] bucket_size_reg;
    lcfk_pkg::queue_out_t q_out;
    logic cmd_pop;
    lcfk_pkg::result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_size_reg <= lcfk_pkg::BW_BITS'(1024);
        end
        else if (cfg_we)
        begin
            bucket_size_reg <= cfg_wdata;
        end
    end

    lcfk_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .s_valid(s_axis_tvalid),
        .s_ready(s_axis_tready),
        .s_cmd  (lcfk_pkg::cmd_t'(s_axis_tdata[75:0])),
        .q_out  (q_out),
        .pop    (cmd_pop)
    );

    lcfk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_in       (q_out),
        .cmd_pop    (cmd_pop),
        .bucket_size(bucket_size_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res)
    );

    assign m_axis_tdata = {5'b0, res};

endmodule
